// ----- src/dsmc_pkg.sv -----
// Shared types, codes and pattern tables of the diamond search controller.
package dsmc_pkg;

    localparam int COORD_W      = 4;   // offset field width, two's complement
    localparam int CAND_W       = 5;   // candidate width, centre plus pattern step
    localparam int PP_W         = 4;   // pattern point counter, holds 0..8
    localparam int MARGIN_W     = 3;
    localparam int BIG_POINTS   = 8;
    localparam int SMALL_POINTS = 4;

    localparam logic OPC_START  = 1'b0;
    localparam logic OPC_COST   = 1'b1;
    localparam logic KIND_REQ   = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_STEP,
        ST_READ
    } t_state;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ORIGIN,
        PH_BIG,
        PH_SMALL
    } t_phase;

    typedef struct packed {
        logic clear;
        logic wr_en;
        logic rd_en;
    } t_mem_ctrl;

    // Large diamond, clockwise from the top point.
    function automatic logic signed [2:0] big_dx(input logic [2:0] p);
        case (p)
            3'd0:    big_dx = 3'sd0;
            3'd1:    big_dx = 3'sd1;
            3'd2:    big_dx = 3'sd2;
            3'd3:    big_dx = 3'sd1;
            3'd4:    big_dx = 3'sd0;
            3'd5:    big_dx = -3'sd1;
            3'd6:    big_dx = -3'sd2;
            default: big_dx = -3'sd1;
        endcase
    endfunction

    function automatic logic signed [2:0] big_dy(input logic [2:0] p);
        case (p)
            3'd0:    big_dy = -3'sd2;
            3'd1:    big_dy = -3'sd1;
            3'd2:    big_dy = 3'sd0;
            3'd3:    big_dy = 3'sd1;
            3'd4:    big_dy = 3'sd2;
            3'd5:    big_dy = 3'sd1;
            3'd6:    big_dy = 3'sd0;
            default: big_dy = -3'sd1;
        endcase
    endfunction

    // Small diamond: up, right, down, left.
    function automatic logic signed [2:0] small_dx(input logic [1:0] p);
        case (p)
            2'd1:    small_dx = 3'sd1;
            2'd3:    small_dx = -3'sd1;
            default: small_dx = 3'sd0;
        endcase
    endfunction

    function automatic logic signed [2:0] small_dy(input logic [1:0] p);
        case (p)
            2'd0:    small_dy = -3'sd1;
            2'd2:    small_dy = 3'sd1;
            default: small_dy = 3'sd0;
        endcase
    endfunction

endpackage

// ----- src/dsmc_cost_mem.sv -----
// Cost store: synchronous single-port RAM plus per-entry known bits.
module dsmc_cost_mem
    import dsmc_pkg::*;
#(
    parameter int DEPTH     = 225,
    parameter int AW        = 8,
    parameter int COST_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_mem_ctrl            i_ctrl,
    input  logic [AW-1:0]        i_addr,
    input  logic [COST_BITS-1:0] i_wdata,
    output logic [COST_BITS-1:0] o_rdata,
    output logic                 o_known
);

    logic [COST_BITS-1:0] r_cost_mem [DEPTH];
    logic [COST_BITS-1:0] r_rdata;
    logic [DEPTH-1:0]     r_known;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_cost_mem[i_addr] <= i_wdata;
        end
        if (i_ctrl.rd_en) begin
            r_rdata <= r_cost_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_known <= '0;
        end else if (i_ctrl.clear) begin
            r_known <= '0;
        end else if (i_ctrl.wr_en) begin
            r_known[i_addr] <= 1'b1;
        end
    end

    assign o_rdata = r_rdata;
    assign o_known = r_known[i_addr];

endmodule

// ----- src/dsmc_seq.sv -----
// Search sequencer: walks the diamond patterns and drives the cost store.
module dsmc_seq
    import dsmc_pkg::*;
#(
    parameter int MAX_MARGIN = 7,
    parameter int COST_BITS  = 24,
    parameter int STORE_AW   = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_opcode,
    input  logic [COST_BITS-1:0]        i_cost,
    input  logic [MARGIN_W-1:0]         i_margin,
    output logic                        o_busy,
    output t_mem_ctrl                   o_mem_ctrl,
    output logic [STORE_AW-1:0]         o_mem_addr,
    output logic [COST_BITS-1:0]        o_mem_wdata,
    input  logic [COST_BITS-1:0]        i_mem_rdata,
    input  logic                        i_mem_known,
    output logic                        o_res_valid,
    output logic                        o_res_kind,
    output logic signed [COORD_W-1:0]   o_res_x,
    output logic signed [COORD_W-1:0]   o_res_y,
    output logic [COST_BITS-1:0]        o_res_cost
);

    localparam int SIDE = 2 * MAX_MARGIN + 1;
    localparam logic [STORE_AW-1:0] ORIGIN_SLOT = STORE_AW'(MAX_MARGIN * SIDE + MAX_MARGIN);
    localparam logic [CAND_W-1:0]   MARGIN_CAP  = CAND_W'(MAX_MARGIN);

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [PP_W-1:0]              r_pp, n_pp;
    logic signed [COORD_W-1:0]    r_cx, n_cx, r_cy, n_cy, r_bx, n_bx, r_by, n_by;
    logic [COST_BITS-1:0]         r_lowest, n_lowest;
    logic                         r_out_valid, n_out_valid, r_out_kind, n_out_kind;
    logic signed [COORD_W-1:0]    r_out_x, n_out_x, r_out_y, n_out_y;
    logic [COST_BITS-1:0]         r_out_cost, n_out_cost;

    logic                         w_acc;
    logic signed [2:0]            w_dx, w_dy;
    logic signed [CAND_W-1:0]     w_cand_x, w_cand_y;
    logic [CAND_W-1:0]            w_mag_x, w_mag_y, w_margin;
    logic                         w_in_win, w_big_done, w_small_done;
    logic [STORE_AW-1:0]          w_slot;

    assign o_busy = (r_state == ST_STEP) || (r_state == ST_READ);
    assign w_acc  = i_start && !o_busy;

    // Current candidate point of the pattern in use.
    always_comb begin
        if (r_phase == PH_BIG) begin
            w_dx = big_dx(r_pp[2:0]);
            w_dy = big_dy(r_pp[2:0]);
        end else begin
            w_dx = small_dx(r_pp[1:0]);
            w_dy = small_dy(r_pp[1:0]);
        end
    end

    assign w_cand_x = CAND_W'(r_cx) + CAND_W'(w_dx);
    assign w_cand_y = CAND_W'(r_cy) + CAND_W'(w_dy);
    assign w_mag_x  = w_cand_x[CAND_W-1] ? (~w_cand_x + 1'b1) : w_cand_x;
    assign w_mag_y  = w_cand_y[CAND_W-1] ? (~w_cand_y + 1'b1) : w_cand_y;
    assign w_margin = (CAND_W'(i_margin) > MARGIN_CAP) ? MARGIN_CAP : CAND_W'(i_margin);
    assign w_in_win = (w_mag_x <= w_margin) && (w_mag_y <= w_margin);
    assign w_slot   = STORE_AW'((int'(w_cand_y) + MAX_MARGIN) * SIDE
                                + int'(w_cand_x) + MAX_MARGIN);

    assign w_big_done   = (r_phase == PH_BIG)   && (r_pp == PP_W'(BIG_POINTS));
    assign w_small_done = (r_phase == PH_SMALL) && (r_pp == PP_W'(SMALL_POINTS));

    assign o_mem_addr  = (r_phase == PH_ORIGIN) ? ORIGIN_SLOT : w_slot;
    assign o_mem_wdata = i_cost;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc && i_opcode == OPC_START) n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (w_acc) n_state = (i_opcode == OPC_START) ? ST_WAIT : ST_STEP;
            end
            ST_STEP: begin
                if (w_big_done) begin
                    n_state = ST_STEP;
                end else if (w_small_done) begin
                    n_state = ST_IDLE;
                end else if (!w_in_win) begin
                    n_state = ST_STEP;
                end else if (i_mem_known) begin
                    n_state = ST_READ;
                end else begin
                    n_state = ST_WAIT;
                end
            end
            ST_READ: begin
                n_state = ST_STEP;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath, store control and result
    always_comb begin
        n_phase     = r_phase;
        n_pp        = r_pp;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_bx        = r_bx;
        n_by        = r_by;
        n_lowest    = r_lowest;
        n_out_valid = 1'b0;
        n_out_kind  = r_out_kind;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_cost  = r_out_cost;
        o_mem_ctrl  = '0;
        case (r_state)
            ST_IDLE, ST_WAIT: begin
                if (w_acc && i_opcode == OPC_START) begin
                    o_mem_ctrl.clear = 1'b1;
                    n_cx        = '0;
                    n_cy        = '0;
                    n_bx        = '0;
                    n_by        = '0;
                    n_lowest    = '0;
                    n_pp        = '0;
                    n_phase     = PH_ORIGIN;
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_REQ;
                    n_out_x     = '0;
                    n_out_y     = '0;
                    n_out_cost  = '0;
                end else if (w_acc && r_state == ST_WAIT) begin
                    o_mem_ctrl.wr_en = 1'b1;
                    if (r_phase == PH_ORIGIN) begin
                        n_lowest = i_cost;
                        n_cx     = '0;
                        n_cy     = '0;
                        n_bx     = '0;
                        n_by     = '0;
                        n_pp     = '0;
                        n_phase  = PH_BIG;
                    end else begin
                        if (i_cost < r_lowest) begin
                            n_lowest = i_cost;
                            n_bx     = w_cand_x[COORD_W-1:0];
                            n_by     = w_cand_y[COORD_W-1:0];
                        end
                        n_pp = r_pp + PP_W'(1);
                    end
                end
            end
            ST_STEP: begin
                if (w_big_done) begin
                    n_pp = '0;
                    if (r_bx != r_cx || r_by != r_cy) begin
                        n_cx = r_bx;
                        n_cy = r_by;
                    end else begin
                        n_phase = PH_SMALL;
                    end
                end else if (w_small_done) begin
                    n_phase     = PH_IDLE;
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_FINAL;
                    n_out_x     = r_bx;
                    n_out_y     = r_by;
                    n_out_cost  = r_lowest;
                end else if (!w_in_win) begin
                    n_pp = r_pp + PP_W'(1);
                end else if (i_mem_known) begin
                    o_mem_ctrl.rd_en = 1'b1;
                end else begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_REQ;
                    n_out_x     = w_cand_x[COORD_W-1:0];
                    n_out_y     = w_cand_y[COORD_W-1:0];
                    n_out_cost  = '0;
                end
            end
            ST_READ: begin
                if (i_mem_rdata < r_lowest) begin
                    n_lowest = i_mem_rdata;
                    n_bx     = w_cand_x[COORD_W-1:0];
                    n_by     = w_cand_y[COORD_W-1:0];
                end
                n_pp = r_pp + PP_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_IDLE;
            r_pp        <= '0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_bx        <= '0;
            r_by        <= '0;
            r_lowest    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_pp        <= n_pp;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_bx        <= n_bx;
            r_by        <= n_by;
            r_lowest    <= n_lowest;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind <= n_out_kind;
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_cost <= n_out_cost;
    end

    assign o_res_valid = r_out_valid;
    assign o_res_kind  = r_out_kind;
    assign o_res_x     = r_out_x;
    assign o_res_y     = r_out_y;
    assign o_res_cost  = r_out_cost;

endmodule

// ----- src/diamond_search_motion_controller_core.sv -----
// Top level of the diamond search motion controller.
//
// Command channel: a transaction is taken on a rising edge with start high and
// busy low. i_opcode 0 starts a new block search (i_cost_value ignored),
// i_opcode 1 returns the cost of the offset asked for last; a cost while no
// search runs is dropped without a result.
// Result channel: o_result_valid marks one cycle carrying o_kind, o_offset_x,
// o_offset_y and o_vec_cost. Kind 0 asks for the cost of an offset, kind 1
// is the final vector with its cost. The receiver cannot stall; every
// transaction yields at most one result.
// Order: a start gives the request for (0,0) in the next cycle. A cost reply is
// stored and gives its result at the end of the pattern walk: a point outside
// the window is skipped, a stored point is read from the cost RAM and compared,
// and each end of a large-diamond pass recentres or starts the small diamond.
// busy stays high over the walk, so one search item is in flight.
// Configuration: i_cfg_valid/o_cfg_ready write search_margin (reset 7), taken
// only while the block is not busy. Reset (i_rst_n low, synchronous) clears the
// known bits of the cost store at once; no clearing pass is needed.
module diamond_search_motion_controller_core
    import dsmc_pkg::*;
#(
    parameter int MAX_MARGIN = 7,
    parameter int COST_BITS  = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_opcode,
    input  logic [COST_BITS-1:0]      i_cost_value,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [MARGIN_W-1:0]       i_cfg_data,
    output logic                      o_result_valid,
    output logic                      o_kind,
    output logic signed [COORD_W-1:0] o_offset_x,
    output logic signed [COORD_W-1:0] o_offset_y,
    output logic [COST_BITS-1:0]      o_vec_cost
);

    // Store holds one entry per offset of the widest window.
    localparam int SIDE     = 2 * MAX_MARGIN + 1;
    localparam int DEPTH    = SIDE * SIDE;
    localparam int STORE_AW = $clog2(DEPTH);

    logic [MARGIN_W-1:0]  r_margin;
    t_mem_ctrl            w_mem_ctrl;
    logic [STORE_AW-1:0]  w_mem_addr;
    logic [COST_BITS-1:0] w_mem_wdata;
    logic [COST_BITS-1:0] w_mem_rdata;
    logic                 w_mem_known;

    // Margin register; writes are held off while a walk runs.
    assign o_cfg_ready = !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= MARGIN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_margin <= i_cfg_data;
        end
    end

    // Sequencer: one candidate point at a time, reads and writes on the store.
    // A store write happens on the cost transaction edge and reads start in the
    // cycle after it at the earliest, so a read never overlaps a pending write.
    dsmc_seq #(
        .MAX_MARGIN (MAX_MARGIN),
        .COST_BITS  (COST_BITS),
        .STORE_AW   (STORE_AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_opcode    (i_opcode),
        .i_cost      (i_cost_value),
        .i_margin    (r_margin),
        .o_busy      (busy),
        .o_mem_ctrl  (w_mem_ctrl),
        .o_mem_addr  (w_mem_addr),
        .o_mem_wdata (w_mem_wdata),
        .i_mem_rdata (w_mem_rdata),
        .i_mem_known (w_mem_known),
        .o_res_valid (o_result_valid),
        .o_res_kind  (o_kind),
        .o_res_x     (o_offset_x),
        .o_res_y     (o_offset_y),
        .o_res_cost  (o_vec_cost)
    );

    // Cost store with known bits, cleared at once on start.
    dsmc_cost_mem #(
        .DEPTH     (DEPTH),
        .AW        (STORE_AW),
        .COST_BITS (COST_BITS)
    ) u_cost_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_mem_ctrl),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata),
        .o_known (w_mem_known)
    );

endmodule

// ----- src/dsmc_checker.sv -----
// Port-level checks of the diamond search controller, bound to the top level.
module dsmc_checker
    import dsmc_pkg::*;
#(
    parameter int COST_BITS = 24
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      i_opcode,
    input logic [COST_BITS-1:0]      i_cost_value,
    input logic                      i_cfg_valid,
    input logic                      o_cfg_ready,
    input logic [MARGIN_W-1:0]       i_cfg_data,
    input logic                      o_result_valid,
    input logic                      o_kind,
    input logic signed [COORD_W-1:0] o_offset_x,
    input logic signed [COORD_W-1:0] o_offset_y,
    input logic [COST_BITS-1:0]      o_vec_cost
);

    // A start always asks for the origin next cycle.
    a_start_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_opcode == OPC_START |=>
            o_result_valid && o_kind == KIND_REQ && o_offset_x == '0 && o_offset_y == '0)
        else $error("start did not request the origin");

    // A cost transaction never produces a result on the following cycle.
    a_cost_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_opcode == OPC_COST |=> !o_result_valid)
        else $error("result too early after cost transaction");

    // Every result leaves the block ready for the next transaction.
    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("busy while a result is shown");

    // Results come from a walk or a start in the previous cycle.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy) || $past(start))
        else $error("result without a cause");

    // Requests carry no cost.
    a_req_zero_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_kind == KIND_REQ |-> o_vec_cost == '0)
        else $error("request with non-zero cost");

endmodule

bind diamond_search_motion_controller_core dsmc_checker #(
    .COST_BITS (COST_BITS)
) u_dsmc_checker (.*);
